@@ rtl/mtlpm_pkg.sv @@
// Shared types and constants for the mount table longest prefix match core.
// Used by mtlpm_ctrl, mtlpm_dp and the top level; depends on nothing else.
package mtlpm_pkg;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic KIND_MOUNT   = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_MATCH = 2'd1;

  localparam int SLOT_OUT_W = 4;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch the accepted item
    logic prep;       // string start / kind change handling
    logic mount;      // one mount byte
    logic scan_step;  // one slot of the resolve scan
    logic scan_end;   // finish a resolve byte
    logic load_out;   // load the result register
  } mtlpm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kind_resolve;
    logic c_zero;
    logic scan_last;
  } mtlpm_sts_t;

endpackage

@@ rtl/mount_table_longest_prefix_match_core.sv @@
// Top level of the mount table longest prefix match core.
// Instantiates mtlpm_ctrl and mtlpm_dp; depends on mtlpm_pkg.
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_kind, in_input_char, in_backend_code
// out      output     out_valid / out_ready  out_op_done, out_status, out_slot,
//                                            out_backend_out, out_rel_offset
//
// Sequence: a mount byte passes accept, prep and the mount step; a resolve byte
// passes accept, prep, the slot scan and scan end. The single read port of the
// prefix memory serves one slot per cycle, so the scan walks every slot in turn.
// Reset: synchronous, active low; slot-used, length and per-string state clear
// at once, the prefix memory needs no clearing pass.
// Stalls: a string terminator holds in its last step until the result register
// is free; the output register lets new items in while a result waits.
module mount_table_longest_prefix_match_core #(
  parameter int MAX_SLOTS  = 16,
  parameter int PREFIX_MAX = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items: one string byte each
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [7:0]                        in_input_char,
  input  logic [2:0]                        in_backend_code,
  // result items: one per terminator byte
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_op_done,
  output logic [1:0]                        out_status,
  output logic [mtlpm_pkg::SLOT_OUT_W-1:0]  out_slot,
  output logic [2:0]                        out_backend_out,
  output logic [$clog2(PREFIX_MAX+1)-1:0]   out_rel_offset
);
  import mtlpm_pkg::*;

  mtlpm_cmd_t cmd;
  mtlpm_sts_t sts;

  // sequencing: accept -> prep -> mount step or slot scan -> result
  mtlpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, prefix memory, match scan and result register
  mtlpm_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .PREFIX_MAX (PREFIX_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_kind),
    .in_input_char   (in_input_char),
    .in_backend_code (in_backend_code),
    .cmd             (cmd),
    .sts             (sts),
    .out_op_done     (out_op_done),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_backend_out (out_backend_out),
    .out_rel_offset  (out_rel_offset)
  );

endmodule

@@ rtl/mtlpm_ctrl.sv @@
// Controller state machine: handshakes, command sequencing, result valid.
// Depends on mtlpm_pkg.
module mtlpm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  mtlpm_pkg::mtlpm_sts_t sts,
  output mtlpm_pkg::mtlpm_cmd_t cmd
);
  import mtlpm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_PREP     = 5'b00010,
    ST_MOUNT    = 5'b00100,
    ST_SCAN     = 5'b01000,
    ST_SCAN_END = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = (sts.kind_resolve == KIND_RESOLVE) ? ST_SCAN : ST_MOUNT;
      end
      ST_MOUNT: begin
        // a terminator holds here until the result register frees up
        if (!sts.c_zero) begin
          cmd.mount = 1'b1;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          cmd.mount    = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        if (!sts.c_zero) begin
          cmd.scan_end = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (out_free) begin
          cmd.scan_end = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in work");

  a_out_from_term: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_MOUNT || state_r == ST_SCAN_END))
    else $error("result raised outside a terminating state");

endmodule

@@ rtl/mtlpm_dp.sv @@
// Datapath: prefix memory, slot table, per-string state, scan and result register.
// Depends on mtlpm_pkg; driven by mtlpm_ctrl commands.
module mtlpm_dp #(
  parameter int MAX_SLOTS  = 16,
  parameter int PREFIX_MAX = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_kind,
  input  logic [7:0]                        in_input_char,
  input  logic [2:0]                        in_backend_code,
  input  mtlpm_pkg::mtlpm_cmd_t             cmd,
  output mtlpm_pkg::mtlpm_sts_t             sts,
  output logic                              out_op_done,
  output logic [1:0]                        out_status,
  output logic [mtlpm_pkg::SLOT_OUT_W-1:0]  out_slot,
  output logic [2:0]                        out_backend_out,
  output logic [$clog2(PREFIX_MAX+1)-1:0]   out_rel_offset
);
  import mtlpm_pkg::*;

  localparam int SIW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NLW   = $clog2(PREFIX_MAX);
  localparam int POSW  = $clog2(PREFIX_MAX + 1);
  localparam int KW    = $clog2(MAX_SLOTS + 1);
  localparam int DEPTH = MAX_SLOTS * PREFIX_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [NLW-1:0]  NORM_MAX = NLW'(PREFIX_MAX - 1);
  localparam logic [POSW-1:0] POS_SAT  = POSW'(PREFIX_MAX);
  localparam logic [KW-1:0]   K_LAST   = KW'(MAX_SLOTS);

  function automatic logic [AW-1:0] mem_addr(input logic [SIW-1:0] s,
                                             input logic [NLW-1:0] p);
    return AW'(AW'(s) * AW'(PREFIX_MAX)) + AW'(p);
  endfunction

  function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SIW-1:0] s);
    logic [SIW+SLOT_OUT_W-1:0] w;
    w = {{SLOT_OUT_W{1'b0}}, s};
    return w[SLOT_OUT_W-1:0];
  endfunction

  // latched item
  logic       kind_r;
  logic [7:0] char_r;
  logic [2:0] be_in_r;

  // per-string state
  logic                 cur_kind_r, cur_kind_nxt;
  logic [POSW-1:0]      pos_r, pos_nxt;
  logic [NLW-1:0]       norm_r, norm_nxt;
  logic                 last_slash_r, last_slash_nxt;
  logic                 start_bad_r, start_bad_nxt;
  logic [MAX_SLOTS-1:0] alive_r, alive_nxt;
  logic [MAX_SLOTS-1:0] slash_r, slash_nxt;

  // slot table
  logic [MAX_SLOTS-1:0] used_r, used_nxt;
  logic [NLW-1:0]       plen_r   [MAX_SLOTS];
  logic [NLW-1:0]       plen_nxt [MAX_SLOTS];
  logic [2:0]           be_store_r [MAX_SLOTS];
  logic                 be_wr_en;

  // prefix memory
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;

  // scan
  logic [KW-1:0]  k_r, k_nxt;
  logic           best_valid_r, best_valid_nxt;
  logic [SIW-1:0] best_idx_r, best_idx_nxt;
  logic [NLW-1:0] win_len_r, win_len_nxt;
  logic           best_slash_r, best_slash_nxt;

  logic           fs_valid;
  logic [SIW-1:0] fs_idx;
  logic           c_zero, is_slash;
  logic [SIW-1:0] j_idx;
  logic [NLW-1:0] pl_j;
  logic [NLW-1:0] rd_pos;
  logic           hit, cand;
  logic           mount_ok;
  logic [1:0]     mount_status;

  assign c_zero   = (char_r == CHAR_NUL);
  assign is_slash = (char_r == CHAR_SLASH);
  assign j_idx    = SIW'(k_r - 1'b1);
  assign pl_j     = plen_r[j_idx];
  assign rd_pos   = (pos_r < POSW'(NORM_MAX)) ? NLW'(pos_r) : '0;

  assign sts.kind_resolve = kind_r;
  assign sts.c_zero       = c_zero;
  assign sts.scan_last    = (k_r == K_LAST);

  // lowest free slot
  always_comb begin
    fs_valid = 1'b0;
    fs_idx   = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        fs_valid = 1'b1;
        fs_idx   = SIW'(i);
      end
    end
  end

  assign mount_ok     = !(start_bad_r || norm_r == '0) && fs_valid;
  assign mount_status = (start_bad_r || norm_r == '0) ? ST_INVALID :
                        (!fs_valid ? ST_FULL : ST_OK);

  always_comb begin
    cur_kind_nxt   = cur_kind_r;
    pos_nxt        = pos_r;
    norm_nxt       = norm_r;
    last_slash_nxt = last_slash_r;
    start_bad_nxt  = start_bad_r;
    alive_nxt      = alive_r;
    slash_nxt      = slash_r;
    used_nxt       = used_r;
    plen_nxt       = plen_r;
    be_wr_en       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = mem_addr(fs_idx, norm_r);
    rd_en          = 1'b0;
    rd_addr        = mem_addr(SIW'(k_r), rd_pos);
    k_nxt          = k_r;
    best_valid_nxt = best_valid_r;
    best_idx_nxt   = best_idx_r;
    win_len_nxt    = win_len_r;
    best_slash_nxt = best_slash_r;
    hit            = 1'b0;
    cand           = 1'b0;

    if (cmd.prep) begin
      // new string, or a kind change drops the partial one
      if (pos_r == '0 || kind_r != cur_kind_r) begin
        cur_kind_nxt   = kind_r;
        start_bad_nxt  = !is_slash;
        pos_nxt        = '0;
        norm_nxt       = '0;
        last_slash_nxt = 1'b0;
        slash_nxt      = '0;
        alive_nxt      = '0;
        if (kind_r == KIND_RESOLVE) begin
          for (int i = 0; i < MAX_SLOTS; i++) begin
            alive_nxt[i] = used_r[i] && (plen_r[i] > NLW'(1));
          end
        end
      end
      k_nxt = '0;
    end

    if (cmd.mount) begin
      if (!c_zero) begin
        if (!start_bad_r && norm_r < NORM_MAX) begin
          if (!(is_slash && last_slash_r)) begin
            wr_en          = fs_valid;
            norm_nxt       = norm_r + 1'b1;
            last_slash_nxt = is_slash;
          end
        end
        if (pos_r < POS_SAT) begin
          pos_nxt = pos_r + 1'b1;
        end
      end else begin
        if (mount_ok) begin
          used_nxt[fs_idx] = 1'b1;
          plen_nxt[fs_idx] = (norm_r > NLW'(1) && last_slash_r) ? norm_r - 1'b1 : norm_r;
          be_wr_en         = 1'b1;
        end
        pos_nxt        = '0;
        norm_nxt       = '0;
        last_slash_nxt = 1'b0;
        start_bad_nxt  = 1'b0;
        alive_nxt      = '0;
        slash_nxt      = '0;
      end
    end

    if (cmd.scan_step) begin
      // read slot k, check slot k-1 against the byte read last cycle
      if (k_r < K_LAST) begin
        rd_en = 1'b1;
      end
      if (k_r == '0) begin
        best_valid_nxt = 1'b0;
        best_idx_nxt   = '0;
        win_len_nxt    = '0;
        best_slash_nxt = 1'b0;
      end else begin
        if (alive_r[j_idx]) begin
          if (pos_r < POSW'(pl_j)) begin
            if (rd_data_r != char_r) begin
              alive_nxt[j_idx] = 1'b0;
            end
          end else if (pos_r == POSW'(pl_j)) begin
            if (is_slash) begin
              slash_nxt[j_idx] = 1'b1;
            end else if (c_zero) begin
              hit = 1'b1;
            end
          end
        end
        // root matches any absolute path; later slot wins ties
        cand = c_zero && !start_bad_r && used_r[j_idx] &&
               (pl_j == NLW'(1) || hit || slash_r[j_idx]);
        if (cand && pl_j >= win_len_r) begin
          best_valid_nxt = 1'b1;
          best_idx_nxt   = j_idx;
          win_len_nxt    = pl_j;
          best_slash_nxt = slash_r[j_idx];
        end
      end
      k_nxt = k_r + 1'b1;
    end

    if (cmd.scan_end) begin
      if (!c_zero) begin
        if (pos_r < POS_SAT) begin
          pos_nxt = pos_r + 1'b1;
        end
      end else begin
        pos_nxt        = '0;
        norm_nxt       = '0;
        last_slash_nxt = 1'b0;
        start_bad_nxt  = 1'b0;
        alive_nxt      = '0;
        slash_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_kind_r   <= KIND_MOUNT;
      pos_r        <= '0;
      norm_r       <= '0;
      last_slash_r <= 1'b0;
      start_bad_r  <= 1'b0;
      alive_r      <= '0;
      slash_r      <= '0;
      used_r       <= '0;
      plen_r       <= '{default: '0};
      k_r          <= '0;
    end else begin
      cur_kind_r   <= cur_kind_nxt;
      pos_r        <= pos_nxt;
      norm_r       <= norm_nxt;
      last_slash_r <= last_slash_nxt;
      start_bad_r  <= start_bad_nxt;
      alive_r      <= alive_nxt;
      slash_r      <= slash_nxt;
      used_r       <= used_nxt;
      plen_r       <= plen_nxt;
      k_r          <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      char_r  <= in_input_char;
      be_in_r <= in_backend_code;
    end
    best_valid_r <= best_valid_nxt;
    best_idx_r   <= best_idx_nxt;
    win_len_r    <= win_len_nxt;
    best_slash_r <= best_slash_nxt;
    if (be_wr_en) begin
      be_store_r[fs_idx] <= be_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= char_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_op_done <= kind_r;
      if (kind_r == KIND_MOUNT) begin
        out_status      <= mount_status;
        out_slot        <= mount_ok ? slot_out(fs_idx) : '0;
        out_backend_out <= '0;
        out_rel_offset  <= '0;
      end else if (best_valid_r) begin
        out_status      <= ST_OK;
        out_slot        <= slot_out(best_idx_r);
        out_backend_out <= be_store_r[best_idx_r];
        out_rel_offset  <= (win_len_r == NLW'(1)) ? '0 :
                           POSW'(win_len_r) + POSW'(best_slash_r);
      end else begin
        out_status      <= ST_NO_MATCH;
        out_slot        <= '0;
        out_backend_out <= '0;
        out_rel_offset  <= '0;
      end
    end
  end

  a_slash_in_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (slash_r & ~alive_r) == '0)
    else $error("slash-after bit set on a dead slot");

  a_alive_used: assert property (@(posedge clk) disable iff (!rst_n)
    (alive_r & ~used_r) == '0)
    else $error("alive bit set on an unused slot");

  a_norm_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    POSW'(norm_r) <= pos_r)
    else $error("normalized length ahead of byte position");

  a_used_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((used_r & $past(used_r)) == $past(used_r)))
    else $error("a used slot was released");

endmodule

@@ verif/tb_mount_table_longest_prefix_match_core.sv @@
// Self-checking testbench for mount_table_longest_prefix_match_core: mount and resolve
// strings go in one byte per item and every result is checked against a local model.
// Depends on mtlpm_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_mount_table_longest_prefix_match_core;
  import mtlpm_pkg::*;

  localparam int NSLOT   = 16;
  localparam int PMAX    = 64;
  localparam int REL_W   = $clog2(PMAX + 1);
  localparam int POS_SAT = 32'hFFFF;
  localparam int N_RAND  = 1500;
  // a resolve byte walks every slot, so allow a few of those per drain
  localparam int DRAIN_CYCLES = 3 * (NSLOT + 4);

  // one accepted byte of a string
  typedef struct {
    logic       kind;
    logic [7:0] ch;
    logic [2:0] be;
    bit         hold;  // wait for every result to drain before offering this item
  } byte_item_t;

  // one result item
  typedef struct packed {
    logic             op_done;
    logic [1:0]       status;
    logic [3:0]       slot;
    logic [2:0]       backend;
    logic [REL_W-1:0] rel;
  } lookup_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_kind;
  logic [7:0]       in_input_char;
  logic [2:0]       in_backend_code;
  logic             out_valid;
  logic             out_ready;
  logic             out_op_done;
  logic [1:0]       out_status;
  logic [3:0]       out_slot;
  logic [2:0]       out_backend_out;
  logic [REL_W-1:0] out_rel_offset;

  mount_table_longest_prefix_match_core #(
    .MAX_SLOTS (NSLOT),
    .PREFIX_MAX(PMAX)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_input_char  (in_input_char),
    .in_backend_code(in_backend_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_op_done    (out_op_done),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_backend_out(out_backend_out),
    .out_rel_offset (out_rel_offset)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Local mount table: prefixes, lengths, backends and the per-string scan state.
  // ---------------------------------------------------------------------------
  logic [7:0]  pfx_mem [NSLOT][PMAX];
  int unsigned pfx_len [NSLOT];
  logic [2:0]  be_mem  [NSLOT];
  bit          slot_busy [NSLOT];
  bit [NSLOT-1:0] alive;        // slots whose prefix still agrees with the path
  bit [NSLOT-1:0] slash_after;  // slots whose full prefix was followed by '/'
  int unsigned pos;             // bytes seen in this string, saturating
  int unsigned norm_len;        // bytes kept of the mount prefix after collapsing
  bit          last_slash;
  bit          bad_start;
  logic        cur_kind;

  lookup_result_t results_due[$];
  byte_item_t     string_bytes[$];
  logic [7:0]     text_buf[$];

  int mismatches;
  int total_items, sent_count;
  int n_mount_ok, n_invalid, n_full, n_matched, n_nomatch;
  bit in_taken;
  byte_item_t nxt;
  int send_idle_pct, recv_idle_pct;

  function automatic void clear_string();
    alive       = '0;
    slash_after = '0;
    pos         = 0;
    norm_len    = 0;
    last_slash  = 0;
    bad_start   = 0;
  endfunction

  // Apply one accepted byte to the table; a terminator queues exactly one result.
  task automatic mount_table_step(input logic kind, input logic [7:0] c, input logic [2:0] be);
    int fs;
    int best;
    int unsigned win_len, pl, rel;
    bit [NSLOT-1:0] hit;
    bit m;
    lookup_result_t r;
    // a kind change drops the partial string without a result
    if (pos != 0 && kind != cur_kind)
      clear_string();
    if (pos == 0) begin
      clear_string();
      cur_kind  = kind;
      bad_start = (c != CHAR_SLASH);
      if (kind == KIND_RESOLVE) begin
        for (int i = 0; i < NSLOT; i++)
          if (slot_busy[i] && pfx_len[i] > 1)
            alive[i] = 1'b1;
      end
    end
    r = '0;
    if (kind == KIND_MOUNT) begin
      fs = -1;
      for (int i = NSLOT - 1; i >= 0; i--)
        if (!slot_busy[i])
          fs = i;
      if (c != CHAR_NUL) begin
        // collapse slash runs, drop bytes past PMAX-1 kept ones
        if (!bad_start && norm_len < PMAX - 1) begin
          if (!(c == CHAR_SLASH && last_slash)) begin
            if (fs >= 0)
              pfx_mem[fs][norm_len] = c;
            norm_len++;
            last_slash = (c == CHAR_SLASH);
          end
        end
        if (pos < POS_SAT)
          pos++;
      end else begin
        r.op_done = KIND_MOUNT;
        // invalid wins over full
        if (bad_start || norm_len == 0) begin
          r.status = ST_INVALID;
          n_invalid++;
        end else if (fs < 0) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          pl = norm_len;
          if (pl > 1 && last_slash)
            pl--;
          pfx_len[fs]   = pl;
          be_mem[fs]    = be;
          slot_busy[fs] = 1'b1;
          r.status      = ST_OK;
          r.slot        = fs[3:0];
          n_mount_ok++;
        end
        results_due.push_back(r);
        clear_string();
      end
    end else begin
      hit = '0;
      for (int i = 0; i < NSLOT; i++) begin
        if (alive[i]) begin
          if (pos < pfx_len[i]) begin
            if (pfx_mem[i][pos] != c)
              alive[i] = 1'b0;
          end else if (pos == pfx_len[i]) begin
            if (c == CHAR_SLASH)
              slash_after[i] = 1'b1;
            else if (c == CHAR_NUL)
              hit[i] = 1'b1;
          end
        end
      end
      if (c != CHAR_NUL) begin
        if (pos < POS_SAT)
          pos++;
      end else begin
        hit |= slash_after;
        best = -1;
        win_len = 0;
        if (!bad_start) begin
          // longest wins, later slot wins ties, root matches any absolute path
          for (int i = 0; i < NSLOT; i++) begin
            if (slot_busy[i]) begin
              m = (pfx_len[i] == 1) || hit[i];
              if (m && pfx_len[i] >= win_len) begin
                win_len = pfx_len[i];
                best = i;
              end
            end
          end
        end
        r.op_done = KIND_RESOLVE;
        if (best < 0) begin
          r.status = ST_NO_MATCH;
          n_nomatch++;
        end else begin
          rel = 0;
          if (win_len != 1)
            rel = win_len + slash_after[best];
          r.status  = ST_OK;
          r.slot    = best[3:0];
          r.backend = be_mem[best];
          r.rel     = rel[REL_W-1:0];
          n_matched++;
        end
        results_due.push_back(r);
        clear_string();
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < 10)
      $display("[%0t] ERROR %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic kind, input logic [7:0] c, input logic [2:0] be,
                            input bit hold);
    byte_item_t it;
    it.kind = kind;
    it.ch   = c;
    it.be   = be;
    it.hold = hold;
    string_bytes.push_back(it);
  endtask

  // text_buf bytes plus the terminator; the backend code rides on every byte
  task automatic queue_string(input logic kind, input logic [2:0] be, input bit hold);
    foreach (text_buf[i])
      queue_byte(kind, text_buf[i], be, hold && i == 0);
    queue_byte(kind, CHAR_NUL, be, hold && text_buf.size() == 0);
  endtask

  task automatic queue_text(input logic kind, input string s, input logic [2:0] be);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++)
      text_buf.push_back(s[i]);
    queue_string(kind, be, 1'b0);
  endtask

  // a small name pool so that paths and prefixes overlap often
  task automatic add_component();
    string names[6];
    int n;
    names = '{"a", "b", "ab", "usr", "lib", "x"};
    if ($urandom_range(19) == 0) begin
      n = $urandom_range(3, 1);
      repeat (n) text_buf.push_back(8'($urandom_range(255, 1)));
    end else begin
      n = $urandom_range(5);
      for (int i = 0; i < names[n].len(); i++)
        text_buf.push_back(names[n][i]);
    end
  endtask

  task automatic build_mount();
    int n;
    text_buf.delete();
    if ($urandom_range(14) == 0)
      add_component();             // does not start with a slash
    if ($urandom_range(9) == 0) begin
      text_buf.push_back(CHAR_SLASH);  // root
    end else begin
      n = $urandom_range(3, 1);
      repeat (n) begin
        text_buf.push_back(CHAR_SLASH);
        if ($urandom_range(3) == 0)
          text_buf.push_back(CHAR_SLASH);
        add_component();
      end
      if ($urandom_range(3) == 0)
        text_buf.push_back(CHAR_SLASH);
    end
  endtask

  task automatic build_path();
    int n;
    text_buf.delete();
    if ($urandom_range(19) == 0)
      add_component();
    n = $urandom_range(4);
    if (n == 0)
      text_buf.push_back(CHAR_SLASH);
    repeat (n) begin
      text_buf.push_back(CHAR_SLASH);
      if ($urandom_range(9) == 0)
        text_buf.push_back(CHAR_SLASH);
      add_component();
    end
    if ($urandom_range(4) == 0)
      text_buf.push_back(CHAR_SLASH);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. The sender and receiver idle
  // rates follow three phases: receiver slow first, sender slow second, then
  // full speed on both sides.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (sent_count * 3 < total_items) begin
        send_idle_pct = 33;
        recv_idle_pct = 64;
      end else if (sent_count * 3 < total_items * 2) begin
        send_idle_pct = 64;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (!in_valid || in_taken) begin
        if (string_bytes.size() > 0 &&
            (!string_bytes[0].hold || results_due.size() == 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          nxt = string_bytes.pop_front();
          in_valid        <= 1'b1;
          in_kind         <= nxt.kind;
          in_input_char   <= nxt.ch;
          in_backend_code <= nxt.be;
          sent_count++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both handshakes sampled on the rising edge. Results are checked
  // before the accepted byte updates the table, so an unexpected result is
  // never hidden by an expectation queued in the same cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lookup_result_t want, got;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_op_done, out_status, out_slot, out_backend_out, out_rel_offset};
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: op=%0d st=%0d slot=%0d",
                                    got.op_done, got.status, got.slot));
        end else begin
          want = results_due.pop_front();
          if (got.op_done !== want.op_done || got.status !== want.status ||
              got.slot !== want.slot || got.backend !== want.backend ||
              got.rel !== want.rel)
            report_mismatch($sformatf(
              "exp op=%0d st=%0d slot=%0d be=%0d rel=%0d, got op=%0d st=%0d slot=%0d be=%0d rel=%0d",
              want.op_done, want.status, want.slot, want.backend, want.rel,
              got.op_done, got.status, got.slot, got.backend, got.rel));
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        mount_table_step(in_kind, in_input_char, in_backend_code);
      end
    end
  end

  // Hard stop in case the core hangs.
  initial begin
    #(10_000_000);
    $display("mount_table_longest_prefix_match_core: mismatch");
    $finish;
  end

  initial begin
    int r, n, base;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_MOUNT;
    in_input_char   = CHAR_NUL;
    in_backend_code = '0;
    out_ready       = 1'b0;
    mismatches      = 0;
    sent_count      = 0;
    in_taken        = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      pfx_len[i]   = 0;
      be_mem[i]    = '0;
      slot_busy[i] = 1'b0;
    end
    clear_string();
    cur_kind = KIND_MOUNT;

    // Directed: empty strings, bad start, root, collapsed slashes with a
    // trailing slash, prefix match with and without a following slash, and a
    // mount cut short by a resolve.
    queue_text(KIND_MOUNT, "", 3'd2);
    queue_text(KIND_RESOLVE, "", 3'd0);
    queue_text(KIND_MOUNT, "x", 3'd1);
    queue_text(KIND_MOUNT, "/", 3'd7);
    queue_text(KIND_MOUNT, "//a/", 3'd5);
    queue_text(KIND_RESOLVE, "/a/b", 3'd0);
    queue_text(KIND_RESOLVE, "/a", 3'd0);
    queue_byte(KIND_MOUNT, CHAR_SLASH, 3'd3, 1'b0);
    queue_byte(KIND_MOUNT, "z", 3'd3, 1'b0);
    queue_text(KIND_RESOLVE, "/q", 3'd0);

    // Random part: mostly well formed mounts and lookups over a shared name pool,
    // with overlong strings early on and some noise.
    base = string_bytes.size();
    n = 0;
    while (string_bytes.size() - base < N_RAND) begin
      if (n == 3) begin
        // overlong mount: kept bytes stop at PMAX-1
        text_buf.delete();
        text_buf.push_back(CHAR_SLASH);
        repeat (75) text_buf.push_back("a");
        queue_string(KIND_MOUNT, 3'd6, 1'b0);
      end else if (n == 8) begin
        // overlong path: past the longest prefix and past the position range
        text_buf.delete();
        text_buf.push_back(CHAR_SLASH);
        repeat (62) text_buf.push_back("a");
        text_buf.push_back(CHAR_SLASH);
        repeat (80) text_buf.push_back("b");
        queue_string(KIND_RESOLVE, 3'd0, 1'b0);
      end else begin
        r = $urandom_range(99);
        if (r < 18) begin
          build_mount();
          queue_string(KIND_MOUNT, 3'($urandom_range(7)), n % 40 == 20);
        end else if (r < 90) begin
          build_path();
          queue_string(KIND_RESOLVE, 3'($urandom_range(7)), n % 40 == 20);
        end else if (r < 95) begin
          // partial string dropped by a kind change
          build_path();
          foreach (text_buf[i])
            queue_byte(r[0], text_buf[i], 3'($urandom_range(7)), 1'b0);
          build_path();
          queue_string(!r[0], 3'($urandom_range(7)), 1'b0);
        end else begin
          // raw bytes, high bits included
          text_buf.delete();
          repeat ($urandom_range(6, 1)) text_buf.push_back(8'($urandom_range(255, 1)));
          queue_string(r[1], 3'($urandom_range(7)), 1'b0);
        end
      end
      n++;
    end
    total_items = string_bytes.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (string_bytes.size() > 0 || in_valid || results_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));

    $display("Sent %0d bytes; mounts: %0d stored, %0d invalid, %0d table full",
             sent_count, n_mount_ok, n_invalid, n_full);
    $display("Lookups: %0d matched, %0d no match; %0d errors", n_matched, n_nomatch,
             mismatches);
    if (mismatches == 0)
      $display("mount_table_longest_prefix_match_core: match");
    else
      $display("mount_table_longest_prefix_match_core: mismatch");
    $finish;
  end

endmodule

@@ mount_table_longest_prefix_match_core.f @@
rtl/mtlpm_pkg.sv
rtl/mtlpm_ctrl.sv
rtl/mtlpm_dp.sv
rtl/mount_table_longest_prefix_match_core.sv
verif/tb_mount_table_longest_prefix_match_core.sv
